/* hdl/sorted_priority_queue_macros.svh */
// assertion macros for the sorted priority queue
// used by the controller and the datapath; needs clock and reset in scope
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTH
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/spq_pkg.sv */
// shared types and constants of the sorted priority queue
// no dependencies
`default_nettype none
package spq_pkg;
   localparam int DEPTH  = 16;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int FILL_W = 5;
   localparam int WORD_W = 32;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;
endpackage
`default_nettype wire

/* hdl/sorted_priority_queue.sv */
// top level of the sorted priority queue, smallest priority served first
// depends on spq_pkg, spq_ctrl and spq_datapath
//
// command channel: a word is taken at a clock edge where start is high and busy is low.
//   req_kind selects insert or remove; req_item_value and req_item_priority carry the entry.
// result channel: every word gives one result on the rsp_ ports, marked by rsp_strobe high for
//   exactly one cycle. the receiver cannot stall, so no result is ever held back.
// the accepted word enters the execute state; at its end the result registers and rsp_strobe
//   are loaded, and the receiver takes the result while rsp_strobe is high.
// busy is high for the single execute cycle, so no word is taken before it ends; in it the
//   row of DEPTH compare-and-shift cells shifts every entry that must move at once.
// an insert on a full queue is refused with rsp_was_full; a remove on an empty queue
//   answers with rsp_was_empty. equal priorities leave in arrival order.
// rsp_fill_count gives the entry count after the word, low 5 bits.
// reset (synchronous, active high) empties the queue and clears the strobe; entry slots
//   keep whatever they held and are never read until written.
`default_nettype none
module sorted_priority_queue
   import spq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_kind,
   input  wire logic signed [WORD_W-1:0] req_item_value,
   input  wire logic signed [WORD_W-1:0] req_item_priority,
   output logic                          rsp_strobe,
   output logic signed [WORD_W-1:0]      rsp_out_value,
   output logic signed [WORD_W-1:0]      rsp_out_priority,
   output logic                          rsp_out_valid,
   output logic                          rsp_was_empty,
   output logic                          rsp_was_full,
   output logic [FILL_W-1:0]             rsp_fill_count
);
   cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (cmd),
      .busy  (busy)
   );

   spq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_kind),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_was_empty     (rsp_was_empty),
      .rsp_was_full      (rsp_was_full),
      .rsp_fill_count    (rsp_fill_count)
   );
endmodule
`default_nettype wire

/* hdl/spq_ctrl.sv */
// controller of the sorted priority queue: accepts a command and sequences one execute cycle
// depends on spq_pkg and sorted_priority_queue_macros.svh
`default_nettype none
`include "sorted_priority_queue_macros.svh"
module spq_ctrl
   import spq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output cmd_type      cmd,
   output logic         busy
);
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      busy     = (state_ff == ST_EXEC);
      cmd.load = start && !busy;
      cmd.exec = busy;
      case (state_ff)
         ST_IDLE: begin
            state_in = cmd.load ? ST_EXEC : ST_IDLE;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SPQ_ASSERT_NEXT(load_enters_exec, cmd.load, state_ff == ST_EXEC, "load did not start exec")
   `SPQ_ASSERT_NEXT(exec_one_cycle, state_ff == ST_EXEC, state_ff == ST_IDLE, "exec lasted")
   `SPQ_ASSERT_SAME(no_load_when_busy, busy, !cmd.load, "load while busy")
endmodule
`default_nettype wire

/* hdl/spq_datapath.sv */
// datapath of the sorted priority queue: row of compare-and-shift cells and result registers
// depends on spq_pkg and sorted_priority_queue_macros.svh
`default_nettype none
`include "sorted_priority_queue_macros.svh"
module spq_datapath
   import spq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   input  wire logic                     req_kind,
   input  wire logic signed [WORD_W-1:0] req_item_value,
   input  wire logic signed [WORD_W-1:0] req_item_priority,
   output logic                          rsp_strobe,
   output logic signed [WORD_W-1:0]      rsp_out_value,
   output logic signed [WORD_W-1:0]      rsp_out_priority,
   output logic                          rsp_out_valid,
   output logic                          rsp_was_empty,
   output logic                          rsp_was_full,
   output logic [FILL_W-1:0]             rsp_fill_count
);
   logic                     kind_ff;
   logic signed [WORD_W-1:0] value_ff;
   logic signed [WORD_W-1:0] prio_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic signed [WORD_W-1:0] ent_val_ff [DEPTH];
   logic signed [WORD_W-1:0] ent_pri_ff [DEPTH];
   logic [DEPTH-1:0]         le;
   logic [DEPTH-1:0]         prev_le;
   logic signed [WORD_W-1:0] prev_val [DEPTH];
   logic signed [WORD_W-1:0] prev_pri [DEPTH];
   logic signed [WORD_W-1:0] next_val [DEPTH];
   logic signed [WORD_W-1:0] next_pri [DEPTH];
   logic                     is_full;
   logic                     is_empty;
   logic                     do_ins;
   logic                     do_rem;
   logic [CNT_W+FILL_W-1:0]  count_ext;

   logic                     strobe_ff;
   logic signed [WORD_W-1:0] out_value_ff;
   logic signed [WORD_W-1:0] out_prio_ff;
   logic                     out_valid_ff;
   logic                     was_empty_ff;
   logic                     was_full_ff;
   logic [FILL_W-1:0]        fill_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         value_ff <= req_item_value;
         prio_ff  <= req_item_priority;
      end
   end

   always_comb begin
      is_full  = (count_ff == CNT_W'(DEPTH));
      is_empty = (count_ff == '0);
      do_ins   = cmd.exec && (kind_ff == KIND_INSERT) && !is_full;
      do_rem   = cmd.exec && (kind_ff == KIND_REMOVE) && !is_empty;
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rem) begin
         count_in = count_ff - CNT_W'(1);
      end
      count_ext = {{FILL_W{1'b0}}, count_in};
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

      assign le[i] = (IDX < count_ff) && (ent_pri_ff[i] <= prio_ff);

      if (i == 0) begin : g_head
         assign prev_le[i]  = 1'b1;
         assign prev_val[i] = value_ff;
         assign prev_pri[i] = prio_ff;
      end else begin : g_body
         assign prev_le[i]  = le[i-1];
         assign prev_val[i] = ent_val_ff[i-1];
         assign prev_pri[i] = ent_pri_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_val[i] = ent_val_ff[i];
         assign next_pri[i] = ent_pri_ff[i];
      end else begin : g_inner
         assign next_val[i] = ent_val_ff[i+1];
         assign next_pri[i] = ent_pri_ff[i+1];
      end

      always_ff @(posedge clock) begin
         if (do_ins && !le[i]) begin
            if (prev_le[i]) begin
               ent_val_ff[i] <= value_ff;
               ent_pri_ff[i] <= prio_ff;
            end else begin
               ent_val_ff[i] <= prev_val[i];
               ent_pri_ff[i] <= prev_pri[i];
            end
         end else if (do_rem) begin
            ent_val_ff[i] <= next_val[i];
            ent_pri_ff[i] <= next_pri[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         out_value_ff <= do_rem ? ent_val_ff[0] : '0;
         out_prio_ff  <= do_rem ? ent_pri_ff[0] : '0;
         out_valid_ff <= do_rem;
         was_empty_ff <= (kind_ff == KIND_REMOVE) && is_empty;
         was_full_ff  <= (kind_ff == KIND_INSERT) && is_full;
         fill_ff      <= count_ext[FILL_W-1:0];
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_out_value    = out_value_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_out_valid    = out_valid_ff;
   assign rsp_was_empty    = was_empty_ff;
   assign rsp_was_full     = was_full_ff;
   assign rsp_fill_count   = fill_ff;

   `SPQ_ASSERT_SAME(count_in_range, 1'b1, count_ff <= CNT_W'(DEPTH), "count beyond depth")
   `SPQ_ASSERT_SAME(one_flag_only, rsp_strobe,
      $countones({rsp_out_valid, rsp_was_empty, rsp_was_full}) <= 1, "conflicting flags")
   `SPQ_ASSERT_NEXT(count_moves_by_one, cmd.exec,
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1))
      || (count_ff == $past(count_ff) - CNT_W'(1)), "count jumped")
endmodule
`default_nettype wire
